/* rtl/core/c6502_pkg.sv */
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types, opcode decode table and address helpers for the 6502
// instruction execute unit.
// ----------------------------------------------------------------------------
package c6502_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;

  localparam logic [7:0] FL_C  = 8'h01;
  localparam logic [7:0] FL_Z  = 8'h02;
  localparam logic [7:0] FL_I  = 8'h04;
  localparam logic [7:0] FL_D  = 8'h08;
  localparam logic [7:0] FL_BU = 8'h30;
  localparam logic [7:0] FL_V  = 8'h40;
  localparam logic [7:0] FL_N  = 8'h80;
  localparam logic [7:0] FL_LOAD_MASK = 8'hCF;

  localparam logic [7:0]  SP_RESET   = 8'hFD;
  localparam logic [7:0]  P_RESET    = 8'h24;
  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [15:0] VEC_BRK_LO = 16'hFFFE;
  localparam logic [15:0] VEC_BRK_HI = 16'hFFFF;

  localparam logic [0:0] ITEM_EXEC    = 1'b0;
  localparam logic [0:0] ITEM_PRELOAD = 1'b1;

  typedef enum logic [3:0] {
    M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_AB, M_ABX, M_ABY,
    M_IND, M_IZX, M_IZY, M_REL
  } addr_mode_e;

  typedef enum logic [5:0] {
    K_ADC, K_AND, K_ASL, K_BCC, K_BCS, K_BEQ, K_BIT, K_BMI, K_BNE, K_BPL, K_BRK, K_BVC,
    K_BVS, K_CLC, K_CLD, K_CLI, K_CLV, K_CMP, K_CPX, K_CPY, K_DEC, K_DEX, K_DEY, K_EOR,
    K_INC, K_INX, K_INY, K_JMP, K_JSR, K_LDA, K_LDX, K_LDY, K_LSR, K_NOP, K_ORA, K_PHA,
    K_PHP, K_PLA, K_PLP, K_ROL, K_ROR, K_RTI, K_RTS, K_SBC, K_SEC, K_SED, K_SEI, K_STA,
    K_STX, K_STY, K_TAX, K_TAY, K_TSX, K_TXA, K_TXS, K_TYA
  } op_kind_e;

  typedef struct packed {
    logic       legal;
    addr_mode_e mode;
    op_kind_e   kind;
    logic [3:0] cyc;
  } dec_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_t;

  typedef struct packed {
    arch_t      arch;
    logic [7:0] wb;
    logic       taken;
  } alu_res_t;

  function automatic dec_t ent(input addr_mode_e m, input op_kind_e k, input logic [3:0] c);
    dec_t d;
    d.legal = 1'b1;
    d.mode  = m;
    d.kind  = k;
    d.cyc   = c;
    return d;
  endfunction

  function automatic dec_t decode_op(input logic [7:0] op);
    dec_t d;
    d.legal = 1'b0;
    d.mode  = M_IMP;
    d.kind  = K_NOP;
    d.cyc   = 4'd1;
    case (op)
      8'h69: d = ent(M_IMM, K_ADC, 4'd2);  8'h65: d = ent(M_ZP,  K_ADC, 4'd3);
      8'h75: d = ent(M_ZPX, K_ADC, 4'd4);  8'h6D: d = ent(M_AB,  K_ADC, 4'd4);
      8'h7D: d = ent(M_ABX, K_ADC, 4'd4);  8'h79: d = ent(M_ABY, K_ADC, 4'd4);
      8'h61: d = ent(M_IZX, K_ADC, 4'd6);  8'h71: d = ent(M_IZY, K_ADC, 4'd5);
      8'h29: d = ent(M_IMM, K_AND, 4'd2);  8'h25: d = ent(M_ZP,  K_AND, 4'd3);
      8'h35: d = ent(M_ZPX, K_AND, 4'd4);  8'h2D: d = ent(M_AB,  K_AND, 4'd4);
      8'h3D: d = ent(M_ABX, K_AND, 4'd4);  8'h39: d = ent(M_ABY, K_AND, 4'd4);
      8'h21: d = ent(M_IZX, K_AND, 4'd6);  8'h31: d = ent(M_IZY, K_AND, 4'd5);
      8'h0A: d = ent(M_ACC, K_ASL, 4'd2);  8'h06: d = ent(M_ZP,  K_ASL, 4'd5);
      8'h16: d = ent(M_ZPX, K_ASL, 4'd6);  8'h0E: d = ent(M_AB,  K_ASL, 4'd6);
      8'h1E: d = ent(M_ABX, K_ASL, 4'd7);
      8'h90: d = ent(M_REL, K_BCC, 4'd2);  8'hB0: d = ent(M_REL, K_BCS, 4'd2);
      8'hF0: d = ent(M_REL, K_BEQ, 4'd2);  8'h30: d = ent(M_REL, K_BMI, 4'd2);
      8'hD0: d = ent(M_REL, K_BNE, 4'd2);  8'h10: d = ent(M_REL, K_BPL, 4'd2);
      8'h50: d = ent(M_REL, K_BVC, 4'd2);  8'h70: d = ent(M_REL, K_BVS, 4'd2);
      8'h24: d = ent(M_ZP,  K_BIT, 4'd3);  8'h2C: d = ent(M_AB,  K_BIT, 4'd4);
      8'h00: d = ent(M_IMP, K_BRK, 4'd7);
      8'h18: d = ent(M_IMP, K_CLC, 4'd2);  8'hD8: d = ent(M_IMP, K_CLD, 4'd2);
      8'h58: d = ent(M_IMP, K_CLI, 4'd2);  8'hB8: d = ent(M_IMP, K_CLV, 4'd2);
      8'hC9: d = ent(M_IMM, K_CMP, 4'd2);  8'hC5: d = ent(M_ZP,  K_CMP, 4'd3);
      8'hD5: d = ent(M_ZPX, K_CMP, 4'd4);  8'hCD: d = ent(M_AB,  K_CMP, 4'd4);
      8'hDD: d = ent(M_ABX, K_CMP, 4'd4);  8'hD9: d = ent(M_ABY, K_CMP, 4'd4);
      8'hC1: d = ent(M_IZX, K_CMP, 4'd6);  8'hD1: d = ent(M_IZY, K_CMP, 4'd5);
      8'hE0: d = ent(M_IMM, K_CPX, 4'd2);  8'hE4: d = ent(M_ZP,  K_CPX, 4'd3);
      8'hEC: d = ent(M_AB,  K_CPX, 4'd4);
      8'hC0: d = ent(M_IMM, K_CPY, 4'd2);  8'hC4: d = ent(M_ZP,  K_CPY, 4'd3);
      8'hCC: d = ent(M_AB,  K_CPY, 4'd4);
      8'hC6: d = ent(M_ZP,  K_DEC, 4'd5);  8'hD6: d = ent(M_ZPX, K_DEC, 4'd6);
      8'hCE: d = ent(M_AB,  K_DEC, 4'd6);  8'hDE: d = ent(M_ABX, K_DEC, 4'd7);
      8'hCA: d = ent(M_IMP, K_DEX, 4'd2);  8'h88: d = ent(M_IMP, K_DEY, 4'd2);
      8'h49: d = ent(M_IMM, K_EOR, 4'd2);  8'h45: d = ent(M_ZP,  K_EOR, 4'd3);
      8'h55: d = ent(M_ZPX, K_EOR, 4'd4);  8'h4D: d = ent(M_AB,  K_EOR, 4'd4);
      8'h5D: d = ent(M_ABX, K_EOR, 4'd4);  8'h59: d = ent(M_ABY, K_EOR, 4'd4);
      8'h41: d = ent(M_IZX, K_EOR, 4'd6);  8'h51: d = ent(M_IZY, K_EOR, 4'd5);
      8'hE6: d = ent(M_ZP,  K_INC, 4'd5);  8'hF6: d = ent(M_ZPX, K_INC, 4'd6);
      8'hEE: d = ent(M_AB,  K_INC, 4'd6);  8'hFE: d = ent(M_ABX, K_INC, 4'd7);
      8'hE8: d = ent(M_IMP, K_INX, 4'd2);  8'hC8: d = ent(M_IMP, K_INY, 4'd2);
      8'h4C: d = ent(M_AB,  K_JMP, 4'd3);  8'h6C: d = ent(M_IND, K_JMP, 4'd5);
      8'h20: d = ent(M_AB,  K_JSR, 4'd6);
      8'hA9: d = ent(M_IMM, K_LDA, 4'd2);  8'hA5: d = ent(M_ZP,  K_LDA, 4'd3);
      8'hB5: d = ent(M_ZPX, K_LDA, 4'd4);  8'hAD: d = ent(M_AB,  K_LDA, 4'd4);
      8'hBD: d = ent(M_ABX, K_LDA, 4'd4);  8'hB9: d = ent(M_ABY, K_LDA, 4'd4);
      8'hA1: d = ent(M_IZX, K_LDA, 4'd6);  8'hB1: d = ent(M_IZY, K_LDA, 4'd5);
      8'hA2: d = ent(M_IMM, K_LDX, 4'd2);  8'hA6: d = ent(M_ZP,  K_LDX, 4'd3);
      8'hB6: d = ent(M_ZPY, K_LDX, 4'd4);  8'hAE: d = ent(M_AB,  K_LDX, 4'd4);
      8'hBE: d = ent(M_ABY, K_LDX, 4'd4);
      8'hA0: d = ent(M_IMM, K_LDY, 4'd2);  8'hA4: d = ent(M_ZP,  K_LDY, 4'd3);
      8'hB4: d = ent(M_ZPX, K_LDY, 4'd4);  8'hAC: d = ent(M_AB,  K_LDY, 4'd4);
      8'hBC: d = ent(M_ABX, K_LDY, 4'd4);
      8'h4A: d = ent(M_ACC, K_LSR, 4'd2);  8'h46: d = ent(M_ZP,  K_LSR, 4'd5);
      8'h56: d = ent(M_ZPX, K_LSR, 4'd6);  8'h4E: d = ent(M_AB,  K_LSR, 4'd6);
      8'h5E: d = ent(M_ABX, K_LSR, 4'd7);
      8'hEA: d = ent(M_IMP, K_NOP, 4'd2);
      8'h09: d = ent(M_IMM, K_ORA, 4'd2);  8'h05: d = ent(M_ZP,  K_ORA, 4'd3);
      8'h15: d = ent(M_ZPX, K_ORA, 4'd4);  8'h0D: d = ent(M_AB,  K_ORA, 4'd4);
      8'h1D: d = ent(M_ABX, K_ORA, 4'd4);  8'h19: d = ent(M_ABY, K_ORA, 4'd4);
      8'h01: d = ent(M_IZX, K_ORA, 4'd6);  8'h11: d = ent(M_IZY, K_ORA, 4'd5);
      8'h48: d = ent(M_IMP, K_PHA, 4'd3);  8'h08: d = ent(M_IMP, K_PHP, 4'd3);
      8'h68: d = ent(M_IMP, K_PLA, 4'd4);  8'h28: d = ent(M_IMP, K_PLP, 4'd4);
      8'h2A: d = ent(M_ACC, K_ROL, 4'd2);  8'h26: d = ent(M_ZP,  K_ROL, 4'd5);
      8'h36: d = ent(M_ZPX, K_ROL, 4'd6);  8'h2E: d = ent(M_AB,  K_ROL, 4'd6);
      8'h3E: d = ent(M_ABX, K_ROL, 4'd7);
      8'h6A: d = ent(M_ACC, K_ROR, 4'd2);  8'h66: d = ent(M_ZP,  K_ROR, 4'd5);
      8'h76: d = ent(M_ZPX, K_ROR, 4'd6);  8'h6E: d = ent(M_AB,  K_ROR, 4'd6);
      8'h7E: d = ent(M_ABX, K_ROR, 4'd7);
      8'h40: d = ent(M_IMP, K_RTI, 4'd6);  8'h60: d = ent(M_IMP, K_RTS, 4'd6);
      8'hE9: d = ent(M_IMM, K_SBC, 4'd2);  8'hE5: d = ent(M_ZP,  K_SBC, 4'd3);
      8'hF5: d = ent(M_ZPX, K_SBC, 4'd4);  8'hED: d = ent(M_AB,  K_SBC, 4'd4);
      8'hFD: d = ent(M_ABX, K_SBC, 4'd4);  8'hF9: d = ent(M_ABY, K_SBC, 4'd4);
      8'hE1: d = ent(M_IZX, K_SBC, 4'd6);  8'hF1: d = ent(M_IZY, K_SBC, 4'd5);
      8'h38: d = ent(M_IMP, K_SEC, 4'd2);  8'hF8: d = ent(M_IMP, K_SED, 4'd2);
      8'h78: d = ent(M_IMP, K_SEI, 4'd2);
      8'h85: d = ent(M_ZP,  K_STA, 4'd3);  8'h95: d = ent(M_ZPX, K_STA, 4'd4);
      8'h8D: d = ent(M_AB,  K_STA, 4'd4);  8'h9D: d = ent(M_ABX, K_STA, 4'd5);
      8'h99: d = ent(M_ABY, K_STA, 4'd5);  8'h81: d = ent(M_IZX, K_STA, 4'd6);
      8'h91: d = ent(M_IZY, K_STA, 4'd6);
      8'h86: d = ent(M_ZP,  K_STX, 4'd3);  8'h96: d = ent(M_ZPY, K_STX, 4'd4);
      8'h8E: d = ent(M_AB,  K_STX, 4'd4);
      8'h84: d = ent(M_ZP,  K_STY, 4'd3);  8'h94: d = ent(M_ZPX, K_STY, 4'd4);
      8'h8C: d = ent(M_AB,  K_STY, 4'd4);
      8'hAA: d = ent(M_IMP, K_TAX, 4'd2);  8'hA8: d = ent(M_IMP, K_TAY, 4'd2);
      8'hBA: d = ent(M_IMP, K_TSX, 4'd2);  8'h8A: d = ent(M_IMP, K_TXA, 4'd2);
      8'h9A: d = ent(M_IMP, K_TXS, 4'd2);  8'h98: d = ent(M_IMP, K_TYA, 4'd2);
      default: d.legal = 1'b0;
    endcase
    return d;
  endfunction

  // Reduce a 16-bit address into [0, m). m >= 1024, so the quotient fits six bits.
  function automatic logic [15:0] mem_wrap(input logic [15:0] a, input int unsigned m);
    logic [31:0] r;
    r = {16'h0000, a};
    for (int k = 5; k >= 0; k--) begin
      if (r >= (32'(m) << k)) begin
        r = r - (32'(m) << k);
      end
    end
    return r[15:0];
  endfunction

  function automatic logic [1:0] instr_len(input addr_mode_e m);
    logic [1:0] l;
    case (m)
      M_IMP, M_ACC:               l = 2'd1;
      M_AB, M_ABX, M_ABY, M_IND:  l = 2'd3;
      default:                    l = 2'd2;
    endcase
    return l;
  endfunction

endpackage

/* rtl/core/c6502_mem.sv */
// ----------------------------------------------------------------------------
// c6502_mem
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module c6502_mem
  import c6502_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
  localparam int unsigned AW = $clog2(MEM_BYTES)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [MEM_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/c6502_alu.sv */
// ----------------------------------------------------------------------------
// c6502_alu
// Register and flag update for every non-stack operation, given the operand.
// ----------------------------------------------------------------------------
module c6502_alu
  import c6502_pkg::*;
(
  input  op_kind_e   kind_i,
  input  addr_mode_e mode_i,
  input  arch_t      arch_i,
  input  logic [7:0] v_i,
  output alu_res_t   res_o
);

  logic [7:0] m;
  logic [8:0] sum;
  logic [7:0] cmp_r;
  logic [8:0] diff;
  logic [7:0] r;
  logic       shift_op;

  always_comb begin
    res_o.arch  = arch_i;
    res_o.wb    = 8'h00;
    res_o.taken = 1'b0;

    m     = (kind_i == K_SBC) ? ~v_i : v_i;
    sum   = {1'b0, arch_i.a} + {1'b0, m} + {8'h00, arch_i.p[0]};
    cmp_r = (kind_i == K_CPX) ? arch_i.x : (kind_i == K_CPY) ? arch_i.y : arch_i.a;
    diff  = {1'b0, cmp_r} - {1'b0, v_i};
    r     = 8'h00;
    shift_op = 1'b0;

    case (kind_i)
      K_ADC, K_SBC: begin
        res_o.arch.a = sum[7:0];
        res_o.arch.p[6] = (~(arch_i.a ^ m) & (arch_i.a ^ sum[7:0])) >> 7 != 8'h00;
        res_o.arch.p[0] = sum[8];
        r = sum[7:0];
      end
      K_AND: begin res_o.arch.a = arch_i.a & v_i; r = arch_i.a & v_i; end
      K_ORA: begin res_o.arch.a = arch_i.a | v_i; r = arch_i.a | v_i; end
      K_EOR: begin res_o.arch.a = arch_i.a ^ v_i; r = arch_i.a ^ v_i; end
      K_ASL: begin r = {v_i[6:0], 1'b0};          res_o.arch.p[0] = v_i[7]; shift_op = 1'b1; end
      K_LSR: begin r = {1'b0, v_i[7:1]};          res_o.arch.p[0] = v_i[0]; shift_op = 1'b1; end
      K_ROL: begin r = {v_i[6:0], arch_i.p[0]};   res_o.arch.p[0] = v_i[7]; shift_op = 1'b1; end
      K_ROR: begin r = {arch_i.p[0], v_i[7:1]};   res_o.arch.p[0] = v_i[0]; shift_op = 1'b1; end
      K_CMP, K_CPX, K_CPY: begin res_o.arch.p[0] = ~diff[8]; r = diff[7:0]; end
      K_DEC: begin r = v_i - 8'd1;      res_o.wb = v_i - 8'd1; end
      K_INC: begin r = v_i + 8'd1;      res_o.wb = v_i + 8'd1; end
      K_DEX: begin r = arch_i.x - 8'd1; res_o.arch.x = arch_i.x - 8'd1; end
      K_DEY: begin r = arch_i.y - 8'd1; res_o.arch.y = arch_i.y - 8'd1; end
      K_INX: begin r = arch_i.x + 8'd1; res_o.arch.x = arch_i.x + 8'd1; end
      K_INY: begin r = arch_i.y + 8'd1; res_o.arch.y = arch_i.y + 8'd1; end
      K_LDA: begin r = v_i; res_o.arch.a = v_i; end
      K_LDX: begin r = v_i; res_o.arch.x = v_i; end
      K_LDY: begin r = v_i; res_o.arch.y = v_i; end
      K_TAX: begin r = arch_i.a;  res_o.arch.x = arch_i.a; end
      K_TAY: begin r = arch_i.a;  res_o.arch.y = arch_i.a; end
      K_TSX: begin r = arch_i.sp; res_o.arch.x = arch_i.sp; end
      K_TXA: begin r = arch_i.x;  res_o.arch.a = arch_i.x; end
      K_TYA: begin r = arch_i.y;  res_o.arch.a = arch_i.y; end
      K_TXS: res_o.arch.sp = arch_i.x;
      K_STA: res_o.wb = arch_i.a;
      K_STX: res_o.wb = arch_i.x;
      K_STY: res_o.wb = arch_i.y;
      K_BCC: res_o.taken = ~arch_i.p[0];
      K_BCS: res_o.taken =  arch_i.p[0];
      K_BNE: res_o.taken = ~arch_i.p[1];
      K_BEQ: res_o.taken =  arch_i.p[1];
      K_BPL: res_o.taken = ~arch_i.p[7];
      K_BMI: res_o.taken =  arch_i.p[7];
      K_BVC: res_o.taken = ~arch_i.p[6];
      K_BVS: res_o.taken =  arch_i.p[6];
      K_CLC: res_o.arch.p[0] = 1'b0;
      K_CLD: res_o.arch.p[3] = 1'b0;
      K_CLI: res_o.arch.p[2] = 1'b0;
      K_CLV: res_o.arch.p[6] = 1'b0;
      K_SEC: res_o.arch.p[0] = 1'b1;
      K_SED: res_o.arch.p[3] = 1'b1;
      K_SEI: res_o.arch.p[2] = 1'b1;
      default: ;
    endcase

    if (shift_op) begin
      res_o.wb = r;
      if (mode_i == M_ACC) begin
        res_o.arch.a = r;
      end
    end

    // Z and N follow r for every operation that sets them, except BIT
    case (kind_i)
      K_ADC, K_SBC, K_AND, K_ORA, K_EOR, K_ASL, K_LSR, K_ROL, K_ROR, K_CMP, K_CPX, K_CPY,
      K_DEC, K_INC, K_DEX, K_DEY, K_INX, K_INY, K_LDA, K_LDX, K_LDY, K_TAX, K_TAY, K_TSX,
      K_TXA, K_TYA: begin
        res_o.arch.p[1] = (r == 8'h00);
        res_o.arch.p[7] = r[7];
      end
      K_BIT: begin
        res_o.arch.p[1] = ((arch_i.a & v_i) == 8'h00);
        res_o.arch.p[7] = v_i[7];
        res_o.arch.p[6] = v_i[6];
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/cpu_6502_instruction_execute_unit.sv */
// ----------------------------------------------------------------------------
// cpu_6502_instruction_execute_unit
// Executes one 6502 instruction per item against A, X, Y, S, P, PC and a
// byte memory that also holds the stack; preload items write one byte.
// ----------------------------------------------------------------------------
// Items are handled one at a time by a sequencer around a single-port memory
// with registered read data, so an item passes through decode, its memory
// accesses and commit before the next item is accepted. A result waits in the
// output register while the next item is accepted. After reset the memory is
// cleared one byte a cycle, so no item is accepted until that pass is over;
// start_pc can be written during that pass.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_execute_unit
  import c6502_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  item_kind_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  operand_low_i,
  input  logic [7:0]  operand_high_i,
  input  logic [7:0]  load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_pc_o,
  output logic [7:0]  acc_o,
  output logic [7:0]  index_x_o,
  output logic [7:0]  index_y_o,
  output logic [7:0]  stack_ptr_o,
  output logic [7:0]  status_flags_o,
  output logic [3:0]  cycles_taken_o,
  output logic        illegal_opcode_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_ADDR, S_PTR1, S_PTR2, S_OPRD, S_OPV, S_EXEC, S_STK, S_DONE
  } state_e;

  state_e      state_q;
  logic [2:0]  step_q;
  arch_t       arch_q;
  logic [15:0] pc_q, npc_q, start_pc_q, ea_q, ptr_q, tmp_q;
  logic [7:0]  lo_q, hi_q, v_q;
  dec_t        dec_q, dec_in;
  logic        px_q;
  logic [3:0]  cyc_q;
  logic        ill_q;
  logic        clearing_q;
  logic [AW-1:0] clr_cnt_q;

  logic        out_valid_q;
  logic [15:0] out_pc_q;
  arch_t       out_arch_q;
  logic [3:0]  out_cyc_q;
  logic        out_ill_q;

  logic        accept, cfg_wr;
  logic        mem_en, mem_we;
  logic [15:0] mem_addr;
  logic [15:0] mem_addr_w;
  logic [AW-1:0] mem_addr_phys;
  logic [7:0]  mem_wdata, rdata;

  logic [15:0] t_abs, ptr_addr, ea_dir, base_ind, ea_ind, pc2, jsr_ret;
  logic [15:0] push_addr, pop_addr;
  logic        needs_read, stack_kind, read_kind, mem_wb, ea_px, ind_px;
  alu_res_t    alu;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'h0000, start_pc_q} : 32'h0000_0000;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  assign in_stall_o = (state_q != S_IDLE) || clearing_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign dec_in     = decode_op(opcode_i);

  assign t_abs    = {hi_q, lo_q};
  assign ptr_addr = (dec_q.mode == M_IND) ? t_abs :
                    (dec_q.mode == M_IZX) ? {8'h00, lo_q + arch_q.x} : {8'h00, lo_q};
  assign base_ind = {rdata, tmp_q[7:0]};
  assign ea_ind   = (dec_q.mode == M_IZY) ? base_ind + {8'h00, arch_q.y} : base_ind;
  assign ind_px   = (dec_q.mode == M_IZY) && (ea_ind[15:8] != base_ind[15:8]);
  assign pc2      = npc_q + 16'd1;
  assign jsr_ret  = npc_q - 16'd1;
  assign push_addr = {STACK_PAGE, arch_q.sp};
  assign pop_addr  = {STACK_PAGE, arch_q.sp + 8'd1};

  always_comb begin
    ea_dir = 16'h0000;
    ea_px  = 1'b0;
    case (dec_q.mode)
      M_ZP:  ea_dir = {8'h00, lo_q};
      M_ZPX: ea_dir = {8'h00, lo_q + arch_q.x};
      M_ZPY: ea_dir = {8'h00, lo_q + arch_q.y};
      M_AB:  ea_dir = t_abs;
      M_ABX: begin
        ea_dir = t_abs + {8'h00, arch_q.x};
        ea_px  = ea_dir[15:8] != hi_q;
      end
      M_ABY: begin
        ea_dir = t_abs + {8'h00, arch_q.y};
        ea_px  = ea_dir[15:8] != hi_q;
      end
      M_REL: ea_dir = npc_q + {{8{lo_q[7]}}, lo_q};
      default: ea_dir = 16'h0000;
    endcase
  end

  always_comb begin
    case (dec_q.kind)
      K_STA, K_STX, K_STY, K_JMP, K_JSR: needs_read = 1'b0;
      default: needs_read = 1'b1;
    endcase
    case (dec_q.kind)
      K_BRK, K_JSR, K_RTS, K_RTI, K_PHA, K_PHP, K_PLA, K_PLP: stack_kind = 1'b1;
      default: stack_kind = 1'b0;
    endcase
    case (dec_q.kind)
      K_ADC, K_AND, K_CMP, K_EOR, K_LDA, K_LDX, K_LDY, K_ORA, K_SBC: read_kind = 1'b1;
      default: read_kind = 1'b0;
    endcase
    case (dec_q.kind)
      K_STA, K_STX, K_STY, K_DEC, K_INC: mem_wb = 1'b1;
      K_ASL, K_LSR, K_ROL, K_ROR: mem_wb = (dec_q.mode != M_ACC);
      default: mem_wb = 1'b0;
    endcase
  end

  c6502_alu u_alu (
    .kind_i (dec_q.kind),
    .mode_i (dec_q.mode),
    .arch_i (arch_q),
    .v_i    (v_q),
    .res_o  (alu)
  );

  // Memory request for the current step
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = 16'h0000;
    mem_wdata = 8'h00;
    case (state_q)
      S_IDLE: begin
        if (accept && (item_kind_i == ITEM_PRELOAD)) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = {operand_high_i, operand_low_i};
          mem_wdata = load_data_i;
        end
      end
      S_ADDR: begin
        if (dec_q.mode == M_IND || dec_q.mode == M_IZX || dec_q.mode == M_IZY) begin
          mem_en   = 1'b1;
          mem_addr = ptr_addr;
        end
      end
      S_PTR1: begin
        mem_en   = 1'b1;
        mem_addr = {ptr_q[15:8], ptr_q[7:0] + 8'd1};
      end
      S_OPRD: begin
        mem_en   = 1'b1;
        mem_addr = ea_q;
      end
      S_EXEC: begin
        if (!stack_kind && mem_wb) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = ea_q;
          mem_wdata = alu.wb;
        end
      end
      S_STK: begin
        case (dec_q.kind)
          K_BRK: begin
            mem_en = (step_q <= 3'd4);
            case (step_q)
              3'd0: begin mem_we = 1'b1; mem_addr = push_addr; mem_wdata = pc2[15:8]; end
              3'd1: begin mem_we = 1'b1; mem_addr = push_addr; mem_wdata = pc2[7:0]; end
              3'd2: begin mem_we = 1'b1; mem_addr = push_addr; mem_wdata = arch_q.p | FL_BU; end
              3'd3: mem_addr = VEC_BRK_LO;
              3'd4: mem_addr = VEC_BRK_HI;
              default: mem_addr = 16'h0000;
            endcase
          end
          K_JSR: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = push_addr;
            mem_wdata = (step_q == 3'd0) ? jsr_ret[15:8] : jsr_ret[7:0];
          end
          K_PHA, K_PHP: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = push_addr;
            mem_wdata = (dec_q.kind == K_PHA) ? arch_q.a : (arch_q.p | FL_BU);
          end
          K_PLA, K_PLP: begin
            mem_en   = (step_q == 3'd0);
            mem_addr = pop_addr;
          end
          K_RTS: begin
            mem_en   = (step_q <= 3'd1);
            mem_addr = pop_addr;
          end
          K_RTI: begin
            mem_en   = (step_q <= 3'd2);
            mem_addr = pop_addr;
          end
          default: mem_en = 1'b0;
        endcase
      end
      default: mem_en = 1'b0;
    endcase
    if (clearing_q) begin
      mem_en    = 1'b1;
      mem_we    = 1'b1;
      mem_wdata = 8'h00;
    end
  end

  assign mem_addr_w    = mem_wrap(mem_addr, MEM_BYTES);
  assign mem_addr_phys = clearing_q ? clr_cnt_q : mem_addr_w[AW-1:0];

  c6502_mem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr_phys),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 3'd0;
      arch_q      <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: P_RESET};
      pc_q        <= 16'h0000;
      start_pc_q  <= 16'h0000;
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      px_q        <= 1'b0;
      cyc_q       <= 4'd0;
      ill_q       <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(MEM_BYTES - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      // a result handed over in S_DONE reloads the register below
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            lo_q  <= operand_low_i;
            hi_q  <= operand_high_i;
            ill_q <= 1'b0;
            px_q  <= 1'b0;
            if (item_kind_i == ITEM_PRELOAD) begin
              cyc_q   <= 4'd0;
              state_q <= S_DONE;
            end else if (!dec_in.legal) begin
              cyc_q   <= 4'd1;
              ill_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              dec_q   <= dec_in;
              npc_q   <= pc_q + {14'h0000, instr_len(dec_in.mode)};
              state_q <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          v_q <= (dec_q.mode == M_IMM) ? lo_q : arch_q.a;
          case (dec_q.mode)
            M_IMP, M_ACC, M_IMM, M_REL: begin
              ea_q    <= ea_dir;
              state_q <= S_EXEC;
            end
            M_IND, M_IZX, M_IZY: begin
              ptr_q   <= ptr_addr;
              state_q <= S_PTR1;
            end
            default: begin
              ea_q    <= ea_dir;
              px_q    <= ea_px;
              state_q <= needs_read ? S_OPRD : S_EXEC;
            end
          endcase
        end
        S_PTR1: begin
          tmp_q   <= {8'h00, rdata};
          state_q <= S_PTR2;
        end
        S_PTR2: begin
          ea_q    <= ea_ind;
          px_q    <= ind_px;
          state_q <= (needs_read && dec_q.kind != K_JMP) ? S_OPRD : S_EXEC;
        end
        S_OPRD: state_q <= S_OPV;
        S_OPV: begin
          v_q     <= rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (stack_kind) begin
            step_q  <= 3'd0;
            state_q <= S_STK;
          end else begin
            arch_q  <= alu.arch;
            state_q <= S_DONE;
            if (dec_q.kind == K_JMP) begin
              pc_q  <= ea_q;
              cyc_q <= dec_q.cyc;
            end else if (alu.taken) begin
              pc_q  <= ea_q;
              cyc_q <= dec_q.cyc + 4'd1 + {3'd0, (npc_q[15:8] != ea_q[15:8])};
            end else begin
              pc_q  <= npc_q;
              cyc_q <= dec_q.cyc + {3'd0, px_q && read_kind};
            end
          end
        end
        S_STK: begin
          step_q <= step_q + 3'd1;
          cyc_q  <= dec_q.cyc;
          case (dec_q.kind)
            K_BRK: begin
              case (step_q)
                3'd0, 3'd1: arch_q.sp <= arch_q.sp - 8'd1;
                3'd2: begin
                  arch_q.sp <= arch_q.sp - 8'd1;
                  arch_q.p  <= arch_q.p | FL_I;
                end
                3'd4: tmp_q <= {8'h00, rdata};
                3'd5: begin
                  pc_q    <= {rdata, tmp_q[7:0]};
                  state_q <= S_DONE;
                end
                default: ;
              endcase
            end
            K_JSR: begin
              arch_q.sp <= arch_q.sp - 8'd1;
              if (step_q == 3'd1) begin
                pc_q    <= ea_q;
                state_q <= S_DONE;
              end
            end
            K_PHA, K_PHP: begin
              arch_q.sp <= arch_q.sp - 8'd1;
              pc_q      <= npc_q;
              state_q   <= S_DONE;
            end
            K_PLA, K_PLP: begin
              if (step_q == 3'd0) begin
                arch_q.sp <= arch_q.sp + 8'd1;
              end else begin
                if (dec_q.kind == K_PLA) begin
                  arch_q.a    <= rdata;
                  arch_q.p[1] <= (rdata == 8'h00);
                  arch_q.p[7] <= rdata[7];
                end else begin
                  arch_q.p <= (rdata & FL_LOAD_MASK) | (arch_q.p & FL_BU);
                end
                pc_q    <= npc_q;
                state_q <= S_DONE;
              end
            end
            K_RTS: begin
              case (step_q)
                3'd0: arch_q.sp <= arch_q.sp + 8'd1;
                3'd1: begin
                  tmp_q     <= {8'h00, rdata};
                  arch_q.sp <= arch_q.sp + 8'd1;
                end
                default: begin
                  pc_q    <= {rdata, tmp_q[7:0]} + 16'd1;
                  state_q <= S_DONE;
                end
              endcase
            end
            K_RTI: begin
              case (step_q)
                3'd0: arch_q.sp <= arch_q.sp + 8'd1;
                3'd1: begin
                  arch_q.p  <= (rdata & FL_LOAD_MASK) | (arch_q.p & FL_BU);
                  arch_q.sp <= arch_q.sp + 8'd1;
                end
                3'd2: begin
                  tmp_q     <= {8'h00, rdata};
                  arch_q.sp <= arch_q.sp + 8'd1;
                end
                default: begin
                  pc_q    <= {rdata, tmp_q[7:0]};
                  state_q <= S_DONE;
                end
              endcase
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_wr) begin
        start_pc_q <= pwdata[15:0];
        pc_q       <= pwdata[15:0];
      end
    end
  end

  // Result payload, loaded when the item is handed to the output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_pc_q   <= pc_q;
      out_arch_q <= arch_q;
      out_cyc_q  <= cyc_q;
      out_ill_q  <= ill_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_pc_o        = out_pc_q;
  assign acc_o            = out_arch_q.a;
  assign index_x_o        = out_arch_q.x;
  assign index_y_o        = out_arch_q.y;
  assign stack_ptr_o      = out_arch_q.sp;
  assign status_flags_o   = out_arch_q.p;
  assign cycles_taken_o   = out_cyc_q;
  assign illegal_opcode_o = out_ill_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: 6502 instruction execute unit
// Drives execute and preload items through the valid/stall ports and checks
// each result field against an in-bench 6502 model; start_pc is written over
// APB between phases, with random idling on both sides and a long output hold.
// ----------------------------------------------------------------------------
module tb;
  import c6502_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [3:0]  cyc;
    logic        ill;
  } cpu_result_t;

  typedef struct {
    bit         ok;
    addr_mode_e m;
    op_kind_e   k;
    int         cyc;
  } op_info_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [0:0]  item_kind_i;
  logic [7:0]  opcode_i, operand_low_i, operand_high_i, load_data_i;
  logic [15:0] next_pc_o;
  logic [7:0]  acc_o, index_x_o, index_y_o, stack_ptr_o, status_flags_o;
  logic [3:0]  cycles_taken_o;
  logic        illegal_opcode_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  cpu_6502_instruction_execute_unit i_dut (.*);

  // model state
  logic [7:0]  m_a, m_x, m_y, m_sp, m_p;
  logic [15:0] m_pc, m_start_pc;
  logic [7:0]  m_mem [65536];

  cpu_result_t expected_q[$];
  int          errors;
  int          send_idle, recv_idle, hold_cycles;
  int unsigned cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic op_info_t oi(addr_mode_e m, op_kind_e k, int c);
    op_info_t d;
    d.ok = 1'b1; d.m = m; d.k = k; d.cyc = c;
    return d;
  endfunction

  function automatic op_info_t decode6502(logic [7:0] op);
    op_info_t d;
    d = oi(M_IMP, K_NOP, 1);
    d.ok = 1'b0;
    case (op)
      8'h69: d = oi(M_IMM,K_ADC,2); 8'h65: d = oi(M_ZP,K_ADC,3); 8'h75: d = oi(M_ZPX,K_ADC,4);
      8'h6D: d = oi(M_AB,K_ADC,4);  8'h7D: d = oi(M_ABX,K_ADC,4); 8'h79: d = oi(M_ABY,K_ADC,4);
      8'h61: d = oi(M_IZX,K_ADC,6); 8'h71: d = oi(M_IZY,K_ADC,5);
      8'h29: d = oi(M_IMM,K_AND,2); 8'h25: d = oi(M_ZP,K_AND,3); 8'h35: d = oi(M_ZPX,K_AND,4);
      8'h2D: d = oi(M_AB,K_AND,4);  8'h3D: d = oi(M_ABX,K_AND,4); 8'h39: d = oi(M_ABY,K_AND,4);
      8'h21: d = oi(M_IZX,K_AND,6); 8'h31: d = oi(M_IZY,K_AND,5);
      8'h0A: d = oi(M_ACC,K_ASL,2); 8'h06: d = oi(M_ZP,K_ASL,5); 8'h16: d = oi(M_ZPX,K_ASL,6);
      8'h0E: d = oi(M_AB,K_ASL,6);  8'h1E: d = oi(M_ABX,K_ASL,7);
      8'h90: d = oi(M_REL,K_BCC,2); 8'hB0: d = oi(M_REL,K_BCS,2); 8'hF0: d = oi(M_REL,K_BEQ,2);
      8'h30: d = oi(M_REL,K_BMI,2); 8'hD0: d = oi(M_REL,K_BNE,2); 8'h10: d = oi(M_REL,K_BPL,2);
      8'h50: d = oi(M_REL,K_BVC,2); 8'h70: d = oi(M_REL,K_BVS,2);
      8'h24: d = oi(M_ZP,K_BIT,3);  8'h2C: d = oi(M_AB,K_BIT,4);  8'h00: d = oi(M_IMP,K_BRK,7);
      8'h18: d = oi(M_IMP,K_CLC,2); 8'hD8: d = oi(M_IMP,K_CLD,2); 8'h58: d = oi(M_IMP,K_CLI,2);
      8'hB8: d = oi(M_IMP,K_CLV,2);
      8'hC9: d = oi(M_IMM,K_CMP,2); 8'hC5: d = oi(M_ZP,K_CMP,3); 8'hD5: d = oi(M_ZPX,K_CMP,4);
      8'hCD: d = oi(M_AB,K_CMP,4);  8'hDD: d = oi(M_ABX,K_CMP,4); 8'hD9: d = oi(M_ABY,K_CMP,4);
      8'hC1: d = oi(M_IZX,K_CMP,6); 8'hD1: d = oi(M_IZY,K_CMP,5);
      8'hE0: d = oi(M_IMM,K_CPX,2); 8'hE4: d = oi(M_ZP,K_CPX,3); 8'hEC: d = oi(M_AB,K_CPX,4);
      8'hC0: d = oi(M_IMM,K_CPY,2); 8'hC4: d = oi(M_ZP,K_CPY,3); 8'hCC: d = oi(M_AB,K_CPY,4);
      8'hC6: d = oi(M_ZP,K_DEC,5);  8'hD6: d = oi(M_ZPX,K_DEC,6); 8'hCE: d = oi(M_AB,K_DEC,6);
      8'hDE: d = oi(M_ABX,K_DEC,7); 8'hCA: d = oi(M_IMP,K_DEX,2); 8'h88: d = oi(M_IMP,K_DEY,2);
      8'h49: d = oi(M_IMM,K_EOR,2); 8'h45: d = oi(M_ZP,K_EOR,3); 8'h55: d = oi(M_ZPX,K_EOR,4);
      8'h4D: d = oi(M_AB,K_EOR,4);  8'h5D: d = oi(M_ABX,K_EOR,4); 8'h59: d = oi(M_ABY,K_EOR,4);
      8'h41: d = oi(M_IZX,K_EOR,6); 8'h51: d = oi(M_IZY,K_EOR,5);
      8'hE6: d = oi(M_ZP,K_INC,5);  8'hF6: d = oi(M_ZPX,K_INC,6); 8'hEE: d = oi(M_AB,K_INC,6);
      8'hFE: d = oi(M_ABX,K_INC,7); 8'hE8: d = oi(M_IMP,K_INX,2); 8'hC8: d = oi(M_IMP,K_INY,2);
      8'h4C: d = oi(M_AB,K_JMP,3);  8'h6C: d = oi(M_IND,K_JMP,5); 8'h20: d = oi(M_AB,K_JSR,6);
      8'hA9: d = oi(M_IMM,K_LDA,2); 8'hA5: d = oi(M_ZP,K_LDA,3); 8'hB5: d = oi(M_ZPX,K_LDA,4);
      8'hAD: d = oi(M_AB,K_LDA,4);  8'hBD: d = oi(M_ABX,K_LDA,4); 8'hB9: d = oi(M_ABY,K_LDA,4);
      8'hA1: d = oi(M_IZX,K_LDA,6); 8'hB1: d = oi(M_IZY,K_LDA,5);
      8'hA2: d = oi(M_IMM,K_LDX,2); 8'hA6: d = oi(M_ZP,K_LDX,3); 8'hB6: d = oi(M_ZPY,K_LDX,4);
      8'hAE: d = oi(M_AB,K_LDX,4);  8'hBE: d = oi(M_ABY,K_LDX,4);
      8'hA0: d = oi(M_IMM,K_LDY,2); 8'hA4: d = oi(M_ZP,K_LDY,3); 8'hB4: d = oi(M_ZPX,K_LDY,4);
      8'hAC: d = oi(M_AB,K_LDY,4);  8'hBC: d = oi(M_ABX,K_LDY,4);
      8'h4A: d = oi(M_ACC,K_LSR,2); 8'h46: d = oi(M_ZP,K_LSR,5); 8'h56: d = oi(M_ZPX,K_LSR,6);
      8'h4E: d = oi(M_AB,K_LSR,6);  8'h5E: d = oi(M_ABX,K_LSR,7); 8'hEA: d = oi(M_IMP,K_NOP,2);
      8'h09: d = oi(M_IMM,K_ORA,2); 8'h05: d = oi(M_ZP,K_ORA,3); 8'h15: d = oi(M_ZPX,K_ORA,4);
      8'h0D: d = oi(M_AB,K_ORA,4);  8'h1D: d = oi(M_ABX,K_ORA,4); 8'h19: d = oi(M_ABY,K_ORA,4);
      8'h01: d = oi(M_IZX,K_ORA,6); 8'h11: d = oi(M_IZY,K_ORA,5);
      8'h48: d = oi(M_IMP,K_PHA,3); 8'h08: d = oi(M_IMP,K_PHP,3); 8'h68: d = oi(M_IMP,K_PLA,4);
      8'h28: d = oi(M_IMP,K_PLP,4);
      8'h2A: d = oi(M_ACC,K_ROL,2); 8'h26: d = oi(M_ZP,K_ROL,5); 8'h36: d = oi(M_ZPX,K_ROL,6);
      8'h2E: d = oi(M_AB,K_ROL,6);  8'h3E: d = oi(M_ABX,K_ROL,7);
      8'h6A: d = oi(M_ACC,K_ROR,2); 8'h66: d = oi(M_ZP,K_ROR,5); 8'h76: d = oi(M_ZPX,K_ROR,6);
      8'h6E: d = oi(M_AB,K_ROR,6);  8'h7E: d = oi(M_ABX,K_ROR,7);
      8'h40: d = oi(M_IMP,K_RTI,6); 8'h60: d = oi(M_IMP,K_RTS,6);
      8'hE9: d = oi(M_IMM,K_SBC,2); 8'hE5: d = oi(M_ZP,K_SBC,3); 8'hF5: d = oi(M_ZPX,K_SBC,4);
      8'hED: d = oi(M_AB,K_SBC,4);  8'hFD: d = oi(M_ABX,K_SBC,4); 8'hF9: d = oi(M_ABY,K_SBC,4);
      8'hE1: d = oi(M_IZX,K_SBC,6); 8'hF1: d = oi(M_IZY,K_SBC,5);
      8'h38: d = oi(M_IMP,K_SEC,2); 8'hF8: d = oi(M_IMP,K_SED,2); 8'h78: d = oi(M_IMP,K_SEI,2);
      8'h85: d = oi(M_ZP,K_STA,3);  8'h95: d = oi(M_ZPX,K_STA,4); 8'h8D: d = oi(M_AB,K_STA,4);
      8'h9D: d = oi(M_ABX,K_STA,5); 8'h99: d = oi(M_ABY,K_STA,5); 8'h81: d = oi(M_IZX,K_STA,6);
      8'h91: d = oi(M_IZY,K_STA,6);
      8'h86: d = oi(M_ZP,K_STX,3);  8'h96: d = oi(M_ZPY,K_STX,4); 8'h8E: d = oi(M_AB,K_STX,4);
      8'h84: d = oi(M_ZP,K_STY,3);  8'h94: d = oi(M_ZPX,K_STY,4); 8'h8C: d = oi(M_AB,K_STY,4);
      8'hAA: d = oi(M_IMP,K_TAX,2); 8'hA8: d = oi(M_IMP,K_TAY,2); 8'hBA: d = oi(M_IMP,K_TSX,2);
      8'h8A: d = oi(M_IMP,K_TXA,2); 8'h9A: d = oi(M_IMP,K_TXS,2); 8'h98: d = oi(M_IMP,K_TYA,2);
      default: ;
    endcase
    return d;
  endfunction

  function automatic void set_flag(logic [7:0] f, bit on);
    m_p = on ? (m_p | f) : (m_p & ~f);
  endfunction

  function automatic void set_zn(logic [7:0] v);
    set_flag(FL_Z, v == 8'h00);
    set_flag(FL_N, v[7]);
  endfunction

  function automatic void push_byte(logic [7:0] v);
    m_mem[{8'h01, m_sp}] = v;
    m_sp = m_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pop_byte();
    m_sp = m_sp + 8'd1;
    return m_mem[{8'h01, m_sp}];
  endfunction

  function automatic void add_to_acc(logic [7:0] m);
    logic [8:0] s;
    s = {1'b0, m_a} + {1'b0, m} + {8'h00, m_p[0]};
    set_flag(FL_V, (~(m_a ^ m) & (m_a ^ s[7:0]) & 8'h80) != 0);
    set_flag(FL_C, s[8]);
    m_a = s[7:0];
    set_zn(m_a);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    set_flag(FL_C, r >= m);
    set_zn(r - m);
  endfunction

  function automatic void restore_flags(logic [7:0] v);
    m_p = (v & FL_LOAD_MASK) | (m_p & FL_BU);
  endfunction

  // Runs one item through the model and returns the register image after it.
  function automatic cpu_result_t run_item(logic [0:0] kind, logic [7:0] op, logic [7:0] lo,
                                           logic [7:0] hi, logic [7:0] dat);
    cpu_result_t res;
    op_info_t    d;
    logic [15:0] t, ea, npc, ptr;
    logic [7:0]  v, r;
    logic [3:0]  cyc;
    bit          px, taken;
    t = {hi, lo};
    ea = 16'h0000;
    px = 0;
    taken = 0;
    r = 8'h00;
    cyc = 4'd0;
    res.ill = 1'b0;
    if (kind == ITEM_PRELOAD) begin
      m_mem[t] = dat;
    end else begin
      d = decode6502(op);
      if (!d.ok) begin
        res.ill = 1'b1;
        cyc = 4'd1;
      end else begin
        npc = m_pc + 16'(instr_len(d.m));
        case (d.m)
          M_ZP:  ea = {8'h00, lo};
          M_ZPX: ea = {8'h00, lo + m_x};
          M_ZPY: ea = {8'h00, lo + m_y};
          M_AB:  ea = t;
          M_ABX: begin ea = t + m_x; px = (t[15:8] != ea[15:8]); end
          M_ABY: begin ea = t + m_y; px = (t[15:8] != ea[15:8]); end
          M_IND: ea = {m_mem[{hi, lo + 8'd1}], m_mem[t]};  // high byte stays in page
          M_IZX: begin
            r = lo + m_x;
            ea = {m_mem[{8'h00, r + 8'd1}], m_mem[{8'h00, r}]};
          end
          M_IZY: begin
            ptr = {m_mem[{8'h00, lo + 8'd1}], m_mem[{8'h00, lo}]};
            ea = ptr + m_y;
            px = (ptr[15:8] != ea[15:8]);
          end
          M_REL: ea = npc + {{8{lo[7]}}, lo};
          default: ;
        endcase
        v = (d.m == M_IMM) ? lo : (d.m == M_ACC) ? m_a : m_mem[ea];
        cyc = 4'(d.cyc);
        r = 8'h00;
        case (d.k)
          K_ADC: add_to_acc(v);
          K_SBC: add_to_acc(~v);
          K_AND: begin m_a = m_a & v; set_zn(m_a); end
          K_ORA: begin m_a = m_a | v; set_zn(m_a); end
          K_EOR: begin m_a = m_a ^ v; set_zn(m_a); end
          K_ASL: begin r = v << 1; set_flag(FL_C, v[7]); end
          K_LSR: begin r = v >> 1; set_flag(FL_C, v[0]); end
          K_ROL: begin r = {v[6:0], m_p[0]}; set_flag(FL_C, v[7]); end
          K_ROR: begin r = {m_p[0], v[7:1]}; set_flag(FL_C, v[0]); end
          K_BIT: begin
            set_flag(FL_Z, (m_a & v) == 0);
            set_flag(FL_N, v[7]);
            set_flag(FL_V, v[6]);
          end
          K_BCC: taken = !m_p[0];
          K_BCS: taken = m_p[0];
          K_BNE: taken = !m_p[1];
          K_BEQ: taken = m_p[1];
          K_BPL: taken = !m_p[7];
          K_BMI: taken = m_p[7];
          K_BVC: taken = !m_p[6];
          K_BVS: taken = m_p[6];
          K_BRK: begin
            t = m_pc + 16'd2;
            push_byte(t[15:8]);
            push_byte(t[7:0]);
            push_byte(m_p | FL_BU);
            set_flag(FL_I, 1);
            npc = {m_mem[VEC_BRK_HI], m_mem[VEC_BRK_LO]};
          end
          K_CLC: set_flag(FL_C, 0);
          K_CLD: set_flag(FL_D, 0);
          K_CLI: set_flag(FL_I, 0);
          K_CLV: set_flag(FL_V, 0);
          K_SEC: set_flag(FL_C, 1);
          K_SED: set_flag(FL_D, 1);
          K_SEI: set_flag(FL_I, 1);
          K_CMP: compare_reg(m_a, v);
          K_CPX: compare_reg(m_x, v);
          K_CPY: compare_reg(m_y, v);
          K_DEC: begin r = v - 8'd1; set_zn(r); m_mem[ea] = r; end
          K_INC: begin r = v + 8'd1; set_zn(r); m_mem[ea] = r; end
          K_DEX: begin m_x = m_x - 8'd1; set_zn(m_x); end
          K_DEY: begin m_y = m_y - 8'd1; set_zn(m_y); end
          K_INX: begin m_x = m_x + 8'd1; set_zn(m_x); end
          K_INY: begin m_y = m_y + 8'd1; set_zn(m_y); end
          K_JMP: npc = ea;
          K_JSR: begin
            t = npc - 16'd1;
            push_byte(t[15:8]);
            push_byte(t[7:0]);
            npc = ea;
          end
          K_LDA: begin m_a = v; set_zn(v); end
          K_LDX: begin m_x = v; set_zn(v); end
          K_LDY: begin m_y = v; set_zn(v); end
          K_PHA: push_byte(m_a);
          K_PHP: push_byte(m_p | FL_BU);
          K_PLA: begin m_a = pop_byte(); set_zn(m_a); end
          K_PLP: restore_flags(pop_byte());
          K_RTI: begin
            restore_flags(pop_byte());
            t[7:0] = pop_byte();
            t[15:8] = pop_byte();
            npc = t;
          end
          K_RTS: begin
            t[7:0] = pop_byte();
            t[15:8] = pop_byte();
            npc = t + 16'd1;
          end
          K_STA: m_mem[ea] = m_a;
          K_STX: m_mem[ea] = m_x;
          K_STY: m_mem[ea] = m_y;
          K_TAX: begin m_x = m_a; set_zn(m_x); end
          K_TAY: begin m_y = m_a; set_zn(m_y); end
          K_TSX: begin m_x = m_sp; set_zn(m_x); end
          K_TXA: begin m_a = m_x; set_zn(m_a); end
          K_TXS: m_sp = m_x;
          K_TYA: begin m_a = m_y; set_zn(m_a); end
          default: ;
        endcase
        if (d.k inside {K_ASL, K_LSR, K_ROL, K_ROR}) begin
          set_zn(r);
          if (d.m == M_ACC) m_a = r;
          else m_mem[ea] = r;
        end
        if (taken) begin
          cyc = cyc + 4'd1;
          if (npc[15:8] != ea[15:8]) cyc = cyc + 4'd1;
          npc = ea;
        end
        // page-cross penalty only for read operations
        if (px && (d.k inside {K_ADC, K_AND, K_CMP, K_EOR, K_LDA, K_LDX, K_LDY, K_ORA, K_SBC}))
          cyc = cyc + 4'd1;
        m_pc = npc;
      end
    end
    res.pc = m_pc; res.a = m_a; res.x = m_x; res.y = m_y;
    res.sp = m_sp; res.p = m_p; res.cyc = cyc;
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(logic [0:0] kind, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                           logic [7:0] dat);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    item_kind_i    <= kind;
    opcode_i       <= op;
    operand_low_i  <= lo;
    operand_high_i <= hi;
    load_data_i    <= dat;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(run_item(kind, op, lo, hi, dat));
  endtask

  task automatic exec(logic [7:0] op, logic [7:0] lo = 8'h00, logic [7:0] hi = 8'h00);
    send_item(ITEM_EXEC, op, lo, hi, 8'($urandom_range(255)));
  endtask

  task automatic poke(logic [15:0] addr, logic [7:0] dat);
    send_item(ITEM_PRELOAD, 8'($urandom_range(255)), addr[7:0], addr[15:8], dat);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_start_pc(logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'd0;
    pwdata  <= {16'h0000, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    m_start_pc = val;
    m_pc = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] pick_page();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hFF;
      3: return 8'h10;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Preloads land mostly on zero page, the stack page, the vector page and page $10 so
  // later reads see data that was written.
  task automatic random_items(int n);
    int sel;
    logic [7:0] op;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 22) begin
        poke({pick_page(), 8'($urandom_range(255))}, 8'($urandom_range(255)));
      end else if (sel < 28) begin
        exec(8'($urandom_range(255)), 8'($urandom_range(255)), pick_page());
      end else begin
        do op = 8'($urandom_range(255)); while (!decode6502(op).ok);
        exec(op, 8'($urandom_range(255)), pick_page());
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    cpu_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, pc %h", $time, next_pc_o);
      end else begin
        e = expected_q.pop_front();
        check_field("next_pc", e.pc, next_pc_o);
        check_field("acc", 16'(e.a), 16'(acc_o));
        check_field("index_x", 16'(e.x), 16'(index_x_o));
        check_field("index_y", 16'(e.y), 16'(index_y_o));
        check_field("stack_ptr", 16'(e.sp), 16'(stack_ptr_o));
        check_field("status_flags", 16'(e.p), 16'(status_flags_o));
        check_field("cycles_taken", 16'(e.cyc), 16'(cycles_taken_o));
        check_field("illegal_opcode", 16'(e.ill), 16'(illegal_opcode_o));
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    poke(VEC_BRK_LO, 8'h34);
    poke(VEC_BRK_HI, 8'h12);
    poke(16'h10FF, 8'h78);
    poke(16'h1000, 8'h56);        // JMP indirect takes its high byte from here
    exec(8'hA9, 8'h80);           // LDA #$80: negative
    exec(8'h69, 8'h7F);           // ADC: mixed signs, no signed overflow
    exec(8'hE9, 8'hFF);           // SBC
    exec(8'hA9, 8'h00);           // zero
    exec(8'hA2, 8'hFF);           // LDX #$FF
    exec(8'hBD, 8'h80, 8'h20);    // LDA abs,X across a page
    exec(8'h9A);                  // TXS: S = FF
    exec(8'h48);                  // PHA: S goes down to FE
    exec(8'h08);                  // PHP with break bits
    exec(8'h28);                  // PLP
    exec(8'h68);                  // PLA
    exec(8'h68);                  // pop past top: S wraps to 00
    exec(8'hF8);                  // SED, no effect on arithmetic
    exec(8'h69, 8'h09);
    exec(8'hD8);
    exec(8'h20, 8'h00, 8'h30);    // JSR
    exec(8'h60);                  // RTS
    exec(8'h00);                  // BRK through the vector
    exec(8'h40);                  // RTI
    exec(8'h6C, 8'hFF, 8'h10);    // JMP ($10FF)
    exec(8'hD0, 8'h80);           // branch taken backward across a page
    exec(8'h02, 8'hFF, 8'hFF);    // undefined opcode
  endtask

  task automatic test_fill_backpressure();
    @(posedge clk_i);
    hold_cycles = 200;            // sender keeps offering meanwhile
    random_items(480);
  endtask

  task automatic test_pause_drain();
    random_items(240);
    drain();
    random_items(240);
  endtask

  task automatic test_full_rate();
    random_items(460);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; item_kind_i = ITEM_EXEC; opcode_i = 8'h00;
    operand_low_i = 8'h00; operand_high_i = 8'h00; load_data_i = 8'h00;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 3'd0; pwdata = 32'h0;
    errors = 0; hold_cycles = 0; cycle_cnt = 0;
    send_idle = 18; recv_idle = 68;
    m_a = 8'h00; m_x = 8'h00; m_y = 8'h00; m_sp = SP_RESET; m_p = P_RESET;
    m_start_pc = 16'h0000; m_pc = 16'h0000;
    for (int i = 0; i < 65536; i++) m_mem[i] = 8'h00;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_start_pc(16'hFFFF);
    test_directed();
    drain();
    write_start_pc(16'h0000);
    test_fill_backpressure();
    drain();
    send_idle = 68; recv_idle = 18;
    write_start_pc(16'h8123);
    test_pause_drain();
    drain();
    send_idle = 0; recv_idle = 0;
    write_start_pc(16'hFFFE);
    test_full_rate();
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
